[src/accel_tilt_roll_pitch_top_macros.svh]
// Assertion macros for the tilt pipeline.
// Used by accel_tilt_roll_pitch_top; expects clk_i and rst_ni in scope.
`ifndef ACCEL_TILT_ROLL_PITCH_TOP_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/atrp_pkg.sv]
// Shared types, constants and the CORDIC arctangent constants for the tilt block.
// No dependencies; imported by atrp_vec, atrp_units and accel_tilt_roll_pitch_top.
package atrp_pkg;

  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COORD_SHIFT  = 40;
  localparam int unsigned COORD_W      = 60;
  localparam int unsigned ANG_W        = 64;
  localparam int unsigned CORDIC_STEPS = 50;
  localparam int unsigned GAIN_W       = 32;
  localparam int unsigned GAIN_FRAC    = 30;
  localparam int unsigned UNIT_STAGES  = 7;

  // CORDIC gain in Q30, pi in Q60, 1/pi in Q64
  localparam logic signed [GAIN_W-1:0] GAIN_Q30   = 32'sd1768195363;
  localparam logic signed [ANG_W-1:0]  PI_Q60     = 64'sh3243F6A8885A308D;
  localparam logic [63:0]              INV_PI_Q64 = 64'h517CC1B727220A94;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } accel_word_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
  } tilt_word_t;

  // atan(2^-i) in Q60: pi/4 for step 0, truncated Taylor terms otherwise.
  // Evaluated at elaboration only.
  function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
    logic signed [ANG_W-1:0] sum;
    logic [63:0]             term;
    sum = '0;
    if (i == 0) begin
      return PI_Q60 >>> 2;
    end
    for (int unsigned k = 0; k < 31; k++) begin
      if (i * (2 * k + 1) <= 60) begin
        term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if ((k & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    return sum;
  endfunction

endpackage

[src/atrp_vec.sv]
// Pipelined CORDIC vectoring unit: one pre-rotation stage and one stage per step.
// Depends on atrp_pkg (widths, pi, arctangent constants).
module atrp_vec (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [atrp_pkg::COORD_W-1:0] a_i,
  input  logic signed [atrp_pkg::COORD_W-1:0] b_i,
  output logic                                valid_o,
  output logic signed [atrp_pkg::COORD_W-1:0] mag_o,
  output logic signed [atrp_pkg::ANG_W-1:0]   ang_o
);
  import atrp_pkg::*;

  localparam int unsigned NREG = CORDIC_STEPS + 1;

  logic                      valid_q [NREG];
  logic                      zero_q  [NREG];
  logic signed [COORD_W-1:0] a_q     [NREG];
  logic signed [COORD_W-1:0] b_q     [NREG];
  logic signed [ANG_W-1:0]   ang_q   [NREG];

  logic                      pre_neg;
  logic signed [COORD_W-1:0] a0_d;
  logic signed [COORD_W-1:0] b0_d;
  logic signed [ANG_W-1:0]   ang0_d;
  logic                      zero0_d;

  // Pre-rotation into the right half plane; a zero vector is flagged
  always_comb begin
    pre_neg = a_i[COORD_W-1];
    zero0_d = (a_i == '0) && (b_i == '0);
    a0_d    = pre_neg ? -a_i : a_i;
    b0_d    = pre_neg ? -b_i : b_i;
    if (pre_neg) begin
      ang0_d = b_i[COORD_W-1] ? -PI_Q60 : PI_Q60;
    end else begin
      ang0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= zero0_d;
      a_q[0]    <= a0_d;
      b_q[0]    <= b0_d;
      ang_q[0]  <= ang0_d;
    end
  end

  // One rotation step per register stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ANG_W-1:0] T_I = atan_step(i);
    logic signed [COORD_W-1:0] da;
    logic signed [COORD_W-1:0] db;
    logic                      b_pos;

    assign da    = b_q[i] >>> i;
    assign db    = a_q[i] >>> i;
    assign b_pos = !b_q[i][COORD_W-1] && (b_q[i] != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (b_pos) begin
          a_q[i+1]   <= a_q[i] + da;
          b_q[i+1]   <= b_q[i] - db;
          ang_q[i+1] <= ang_q[i] + T_I;
        end else begin
          a_q[i+1]   <= a_q[i] - da;
          b_q[i+1]   <= b_q[i] + db;
          ang_q[i+1] <= ang_q[i] - T_I;
        end
      end
    end
  end

  // atan2(0,0) reads as zero
  assign valid_o = valid_q[NREG-1];
  assign mag_o   = a_q[NREG-1];
  assign ang_o   = zero_q[NREG-1] ? '0 : ang_q[NREG-1];

endmodule

[src/atrp_units.sv]
// Radians (Q60) to rounded binary angle units, with saturation, in seven stages.
// Depends on atrp_pkg (ANGLE_BITS, 1/pi constant).
module atrp_units (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic                                  flip_i,
  input  logic signed [atrp_pkg::ANG_W-1:0]     rad_i,
  output logic signed [atrp_pkg::ANGLE_BITS-1:0] angle_o
);
  import atrp_pkg::*;

  localparam int unsigned RSH     = 61 - ANGLE_BITS;
  localparam int unsigned UNITS_W = ANG_W - RSH;
  localparam logic [63:0] ROUND   = 64'd1 << (60 - ANGLE_BITS);
  localparam logic [UNITS_W-1:0] TOP_U = UNITS_W'(1) << (ANGLE_BITS - 1);
  localparam logic [31:0] C_LO = INV_PI_Q64[31:0];
  localparam logic [31:0] C_HI = INV_PI_Q64[63:32];

  logic [5:0]         neg_q;
  logic [63:0]        m0_q;
  logic [63:0]        p0_q, p1_q, p0b_q, p1b_q, p2_q, p3_q;
  logic [31:0]        mh1_q;
  logic [33:0]        mid3_q;
  logic [63:0]        hi3_q;
  logic [63:0]        q4_q;
  logic [63:0]        rsum;
  logic [UNITS_W-1:0] u5_q;
  logic [UNITS_W-1:0] sat;
  logic [UNITS_W-1:0] sat_n;
  logic signed [ANGLE_BITS-1:0] angle_d;
  logic signed [ANGLE_BITS-1:0] angle_q;

  // Rounding offset, then saturate and restore the sign
  always_comb begin
    rsum  = q4_q + ROUND;
    sat   = '0;
    sat_n = '0;
    if (neg_q[5]) begin
      sat     = (u5_q > TOP_U) ? TOP_U : u5_q;
      sat_n   = UNITS_W'(0) - sat;
      angle_d = sat_n[ANGLE_BITS-1:0];
    end else begin
      sat     = (u5_q > TOP_U - UNITS_W'(1)) ? TOP_U - UNITS_W'(1) : u5_q;
      angle_d = sat[ANGLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // magnitude and sign
      neg_q[0] <= rad_i[ANG_W-1] ^ flip_i;
      m0_q     <= rad_i[ANG_W-1] ? 64'(-rad_i) : 64'(rad_i);
      // low half of m times 1/pi
      neg_q[1] <= neg_q[0];
      p0_q     <= m0_q[31:0] * C_LO;
      p1_q     <= m0_q[31:0] * C_HI;
      mh1_q    <= m0_q[63:32];
      // high half of m times 1/pi
      neg_q[2] <= neg_q[1];
      p0b_q    <= p0_q;
      p1b_q    <= p1_q;
      p2_q     <= mh1_q * C_LO;
      p3_q     <= mh1_q * C_HI;
      // partial product sums
      neg_q[3] <= neg_q[2];
      mid3_q   <= {2'b0, p0b_q[63:32]} + {2'b0, p1b_q[31:0]} + {2'b0, p2_q[31:0]};
      hi3_q    <= p3_q + {32'b0, p1b_q[63:32]} + {32'b0, p2_q[63:32]};
      // upper 64 bits of the product
      neg_q[4] <= neg_q[3];
      q4_q     <= hi3_q + {62'b0, mid3_q[33:32]};
      // round to units
      neg_q[5] <= neg_q[4];
      u5_q     <= rsum[63:RSH];
      // saturated signed result
      angle_q  <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

[src/accel_tilt_roll_pitch_top.sv]
// Accelerometer tilt: roll = atan2(y, z), pitch = -atan2(x, |(y, z)|).
// Input channel:  in_valid_i / in_stall_o / in_data_i  (accel_x, accel_y, accel_z).
// Output channel: out_valid_o / out_stall_i / out_data_o (roll_angle, pitch_angle),
//   angles in units of pi / 2^(ANGLE_BITS-1), rounded to nearest, +pi saturated.
// A word is taken at a rising edge with valid high and stall low.
// Throughput: one word per cycle, with no gaps while in_stall_o stays low.
// Pipeline, in order: 51 stages of roll CORDIC (pre-rotation plus 50 steps),
//   51 stages of pitch CORDIC, 7 stages of radian-to-unit conversion (64x64 high
//   product split into 32x32 partial products), and the output register.
// Reset (rst_ni low, asynchronous) clears every valid bit; words in flight are
//   dropped and the block accepts input on the first cycle after reset.
// When the receiver stalls, the output register holds its word and one more
//   word lands in the skid register; once the skid register is full, in_stall_o
//   rises and the whole pipeline holds until the output is taken.
`include "accel_tilt_roll_pitch_top_macros.svh"

module accel_tilt_roll_pitch_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  atrp_pkg::accel_word_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output atrp_pkg::tilt_word_t  out_data_o
);
  import atrp_pkg::*;

  localparam int unsigned XG_W    = SAMPLE_W + GAIN_W;
  localparam int unsigned XG_PAD  = COORD_SHIFT - GAIN_FRAC;
  localparam int unsigned SAMP_EXT = COORD_W - SAMPLE_W - COORD_SHIFT;
  localparam int unsigned XG_EXT  = COORD_W - XG_W - XG_PAD;
  localparam int unsigned RD      = CORDIC_STEPS + 1;

  logic en;

  // Roll CORDIC on (z, y)
  logic signed [COORD_W-1:0] roll_a, roll_b;
  logic                      roll_valid;
  logic signed [COORD_W-1:0] roll_mag;
  logic signed [ANG_W-1:0]   roll_ang;

  assign roll_a = {{SAMP_EXT{in_data_i.accel_z[SAMPLE_W-1]}}, in_data_i.accel_z,
                   {COORD_SHIFT{1'b0}}};
  assign roll_b = {{SAMP_EXT{in_data_i.accel_y[SAMPLE_W-1]}}, in_data_i.accel_y,
                   {COORD_SHIFT{1'b0}}};

  atrp_vec u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a_i     (roll_a),
    .b_i     (roll_b),
    .valid_o (roll_valid),
    .mag_o   (roll_mag),
    .ang_o   (roll_ang)
  );

  // x rides alongside the roll pipe, then gets the CORDIC gain applied
  logic signed [SAMPLE_W-1:0] x_q [CORDIC_STEPS];
  logic signed [XG_W-1:0]     xg_q;
  logic signed [GAIN_W-1:0]   gain_s;

  assign gain_s = GAIN_Q30;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= in_data_i.accel_x;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        x_q[k] <= x_q[k-1];
      end
      xg_q <= x_q[CORDIC_STEPS-1] * gain_s;
    end
  end

  // Pitch CORDIC on (roll magnitude, x * gain)
  logic signed [COORD_W-1:0] pitch_b;
  logic                      pitch_valid;
  logic signed [COORD_W-1:0] pitch_mag;
  logic signed [ANG_W-1:0]   pitch_ang;

  assign pitch_b = {{XG_EXT{xg_q[XG_W-1]}}, xg_q, {XG_PAD{1'b0}}};

  atrp_vec u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (roll_valid),
    .a_i     (roll_mag),
    .b_i     (pitch_b),
    .valid_o (pitch_valid),
    .mag_o   (pitch_mag),
    .ang_o   (pitch_ang)
  );

  // Roll angle waits for the pitch pipe
  logic signed [ANG_W-1:0] rang_q [RD];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rang_q[0] <= roll_ang;
      for (int k = 1; k < RD; k++) begin
        rang_q[k] <= rang_q[k-1];
      end
    end
  end

  // Unit conversion; pitch takes the negated angle through the flip input
  logic signed [ANGLE_BITS-1:0] roll_units, pitch_units;
  logic [UNIT_STAGES-1:0]       uv_q;

  atrp_units u_roll_units (
    .clk_i   (clk_i),
    .en_i    (en),
    .flip_i  (1'b0),
    .rad_i   (rang_q[RD-1]),
    .angle_o (roll_units)
  );

  atrp_units u_pitch_units (
    .clk_i   (clk_i),
    .en_i    (en),
    .flip_i  (1'b1),
    .rad_i   (pitch_ang),
    .angle_o (pitch_units)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_q <= '0;
    end else if (en) begin
      uv_q <= {uv_q[UNIT_STAGES-2:0], pitch_valid};
    end
  end

  // Output register with a one-word skid register
  tilt_word_t pipe_word;
  logic       pipe_valid;
  tilt_word_t out_q, out_d, skid_q, skid_d;
  logic       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic       take;

  assign pipe_word.roll_angle  = roll_units;
  assign pipe_word.pitch_angle = pitch_units;
  assign pipe_valid = uv_q[UNIT_STAGES-1];
  assign take       = out_valid_q && !out_stall_i;
  assign en         = !skid_valid_q;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = pipe_word;
        out_valid_d = pipe_valid;
      end
    end else if (pipe_valid && en) begin
      skid_d       = pipe_word;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `ATRP_ASSERT_NOW(a_skid_needs_out, skid_valid_q, out_valid_q,
                   "skid word held without an output word")
  `ATRP_ASSERT_NOW(a_skid_fill_on_stall, $rose(skid_valid_q),
                   $past(out_valid_q && out_stall_i),
                   "skid filled while output was not stalled")
  `ATRP_ASSERT_NEXT(a_pipe_frozen, skid_valid_q, $stable(uv_q) && $stable(pitch_valid),
                    "pipeline moved while skid register was full")

endmodule
